// ----- src/rti_pkg.sv -----
// ----------------------------------------------------------------------------
// rti_pkg
// Shared widths, codes and payload types of the ray/triangle intersector.
// ----------------------------------------------------------------------------
package rti_pkg;

    localparam int CW    = 32;   // coordinate
    localparam int EW    = 33;   // edge or origin difference
    localparam int PW    = 66;   // P = D x e2
    localparam int QW    = 67;   // Q = T x e1
    localparam int MW    = 99;   // one dot product term
    localparam int DW    = 101;  // det and both numerators
    localparam int SPLIT = 33;   // low slice of a wide multiplicand
    localparam int IW    = 3;    // register index

    localparam logic [1:0] OUT_HIT  = 2'd0;
    localparam logic [1:0] OUT_PAR  = 2'd1;
    localparam logic [1:0] OUT_UOUT = 2'd2;
    localparam logic [1:0] OUT_VOUT = 2'd3;

    localparam logic [IW-1:0] REG_ORG_X = 3'd0;
    localparam logic [IW-1:0] REG_ORG_Y = 3'd1;
    localparam logic [IW-1:0] REG_ORG_Z = 3'd2;
    localparam logic [IW-1:0] REG_DIR_X = 3'd3;
    localparam logic [IW-1:0] REG_DIR_Y = 3'd4;
    localparam logic [IW-1:0] REG_DIR_Z = 3'd5;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } t_v32;

    typedef struct packed {
        logic signed [EW-1:0] x;
        logic signed [EW-1:0] y;
        logic signed [EW-1:0] z;
    } t_v33;

    typedef struct packed {
        logic signed [PW-1:0] x;
        logic signed [PW-1:0] y;
        logic signed [PW-1:0] z;
    } t_vp;

    typedef struct packed {
        logic signed [QW-1:0] x;
        logic signed [QW-1:0] y;
        logic signed [QW-1:0] z;
    } t_vq;

    // triangle data kept for the final point
    typedef struct packed {
        t_v32 a;
        t_v33 e1;
        t_v33 e2;
    } t_tri;

    typedef struct packed {
        t_tri trg;
        t_v33 t;
        t_vp  p;
        t_vq  q;
    } t_xs;

    typedef struct packed {
        t_tri                 trg;
        logic signed [DW-1:0] det;
        logic signed [DW-1:0] nu;
        logic signed [DW-1:0] nv;
    } t_dots;

endpackage

// ----- src/ray_triangle_intersect.sv -----
// ----------------------------------------------------------------------------
// ray_triangle_intersect
// Ray/triangle intersection in signed fixed point, one triangle per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   The ray origin and direction sit in six 32-bit registers written through
//   i_cfg_wr_en / i_cfg_idx / i_cfg_data (index 0..5: origin x,y,z, then
//   direction x,y,z; other indexes are ignored). Write them while idle.
//   Triangles enter on the input channel (i_in_valid, o_in_stall); a transfer
//   happens on a clock edge with valid high and stall low. Each triangle
//   gives one result on the output channel (o_out_valid, i_out_stall):
//   outcome code and hit point, the point being zero unless it is a hit.
//   Data passes through the cross products, the dot products, the pipelined
//   divider (one quotient bit per stage) and the point. Throughput is one
//   triangle per cycle while the receiver does not stall. Every stage has
//   its own valid bit; while the receiver stalls, empty stages keep filling,
//   so input is still taken until the pipeline is full. Nothing is lost or
//   repeated.
//   Reset (synchronous, active low) empties the pipeline and clears the
//   ray registers to zero.
// ----------------------------------------------------------------------------
module ray_triangle_intersect #(
    parameter int FRAC_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [rti_pkg::IW-1:0]       i_cfg_idx,
    input  logic [rti_pkg::CW-1:0]       i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic signed [rti_pkg::CW-1:0] i_a_x,
    input  logic signed [rti_pkg::CW-1:0] i_a_y,
    input  logic signed [rti_pkg::CW-1:0] i_a_z,
    input  logic signed [rti_pkg::CW-1:0] i_b_x,
    input  logic signed [rti_pkg::CW-1:0] i_b_y,
    input  logic signed [rti_pkg::CW-1:0] i_b_z,
    input  logic signed [rti_pkg::CW-1:0] i_c_x,
    input  logic signed [rti_pkg::CW-1:0] i_c_y,
    input  logic signed [rti_pkg::CW-1:0] i_c_z,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [1:0]                   o_outcome,
    output logic signed [rti_pkg::CW-1:0] o_hit_x,
    output logic signed [rti_pkg::CW-1:0] o_hit_y,
    output logic signed [rti_pkg::CW-1:0] o_hit_z
);
    import rti_pkg::*;

    t_v32 r_org, r_dir;
    t_v32 in_a, in_b, in_c, hit;

    logic  cr_ready, cr_valid, dt_ready, dt_valid;
    logic  dv_ready, dv_valid, pt_ready;
    t_xs   xs;
    t_dots dots;
    t_tri  dv_tri;
    logic  dv_par;
    logic signed [FRAC_BITS+3:0] dv_u, dv_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org <= '0;
            r_dir <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                REG_ORG_X: r_org.x <= i_cfg_data;
                REG_ORG_Y: r_org.y <= i_cfg_data;
                REG_ORG_Z: r_org.z <= i_cfg_data;
                REG_DIR_X: r_dir.x <= i_cfg_data;
                REG_DIR_Y: r_dir.y <= i_cfg_data;
                REG_DIR_Z: r_dir.z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign in_a = '{x: i_a_x, y: i_a_y, z: i_a_z};
    assign in_b = '{x: i_b_x, y: i_b_y, z: i_b_z};
    assign in_c = '{x: i_c_x, y: i_c_y, z: i_c_z};

    assign o_in_stall = !cr_ready;

    rti_cross u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_org   (r_org),
        .i_dir   (r_dir),
        .i_valid (i_in_valid),
        .o_ready (cr_ready),
        .i_a     (in_a),
        .i_b     (in_b),
        .i_c     (in_c),
        .o_valid (cr_valid),
        .i_ready (dt_ready),
        .o_xs    (xs)
    );

    rti_dot u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_dir   (r_dir),
        .i_valid (cr_valid),
        .o_ready (dt_ready),
        .i_xs    (xs),
        .o_valid (dt_valid),
        .i_ready (dv_ready),
        .o_dots  (dots)
    );

    rti_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dt_valid),
        .o_ready (dv_ready),
        .i_dots  (dots),
        .o_valid (dv_valid),
        .i_ready (pt_ready),
        .o_tri   (dv_tri),
        .o_par   (dv_par),
        .o_u     (dv_u),
        .o_v     (dv_v)
    );

    rti_point #(
        .FRAC_BITS (FRAC_BITS)
    ) u_point (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (dv_valid),
        .o_ready   (pt_ready),
        .i_tri     (dv_tri),
        .i_par     (dv_par),
        .i_u       (dv_u),
        .i_v       (dv_v),
        .o_valid   (o_out_valid),
        .i_ready   (!i_out_stall),
        .o_outcome (o_outcome),
        .o_hit     (hit)
    );

    assign o_hit_x = hit.x;
    assign o_hit_y = hit.y;
    assign o_hit_z = hit.z;

endmodule

// ----- src/rti_cross.sv -----
// ----------------------------------------------------------------------------
// rti_cross
// Edges, origin offset and the two cross products P = D x e2, Q = T x e1.
// Three stages: differences, products, product differences.
// ----------------------------------------------------------------------------
module rti_cross (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  rti_pkg::t_v32 i_org,
    input  rti_pkg::t_v32 i_dir,
    input  logic          i_valid,
    output logic          o_ready,
    input  rti_pkg::t_v32 i_a,
    input  rti_pkg::t_v32 i_b,
    input  rti_pkg::t_v32 i_c,
    output logic          o_valid,
    input  logic          i_ready,
    output rti_pkg::t_xs  o_xs
);
    import rti_pkg::*;

    localparam int NS = 3;

    logic [NS:0]   en;
    logic [NS-1:0] r_vld;

    t_v32 r0_a;
    t_v33 r0_e1, r0_e2, r0_t;

    logic signed [CW+EW-1:0] r1_dp [6];
    logic signed [2*EW-1:0]  r1_tp [6];
    t_v32 r1_a;
    t_v33 r1_e1, r1_e2, r1_t;

    t_xs r2_xs;

    always_comb begin
        en[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_vld[NS-1];
    assign o_xs    = r2_xs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) r_vld[0] <= i_valid;
            for (int k = 1; k < NS; k++) begin
                if (en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r0_a    <= i_a;
            r0_e1.x <= EW'(i_b.x) - EW'(i_a.x);
            r0_e1.y <= EW'(i_b.y) - EW'(i_a.y);
            r0_e1.z <= EW'(i_b.z) - EW'(i_a.z);
            r0_e2.x <= EW'(i_c.x) - EW'(i_a.x);
            r0_e2.y <= EW'(i_c.y) - EW'(i_a.y);
            r0_e2.z <= EW'(i_c.z) - EW'(i_a.z);
            r0_t.x  <= EW'(i_org.x) - EW'(i_a.x);
            r0_t.y  <= EW'(i_org.y) - EW'(i_a.y);
            r0_t.z  <= EW'(i_org.z) - EW'(i_a.z);
        end
        if (en[1]) begin
            r1_dp[0] <= i_dir.y * r0_e2.z;
            r1_dp[1] <= i_dir.z * r0_e2.y;
            r1_dp[2] <= i_dir.z * r0_e2.x;
            r1_dp[3] <= i_dir.x * r0_e2.z;
            r1_dp[4] <= i_dir.x * r0_e2.y;
            r1_dp[5] <= i_dir.y * r0_e2.x;
            r1_tp[0] <= r0_t.y * r0_e1.z;
            r1_tp[1] <= r0_t.z * r0_e1.y;
            r1_tp[2] <= r0_t.z * r0_e1.x;
            r1_tp[3] <= r0_t.x * r0_e1.z;
            r1_tp[4] <= r0_t.x * r0_e1.y;
            r1_tp[5] <= r0_t.y * r0_e1.x;
            r1_a     <= r0_a;
            r1_e1    <= r0_e1;
            r1_e2    <= r0_e2;
            r1_t     <= r0_t;
        end
        if (en[2]) begin
            r2_xs.trg.a  <= r1_a;
            r2_xs.trg.e1 <= r1_e1;
            r2_xs.trg.e2 <= r1_e2;
            r2_xs.t      <= r1_t;
            r2_xs.p.x    <= PW'(r1_dp[0]) - PW'(r1_dp[1]);
            r2_xs.p.y    <= PW'(r1_dp[2]) - PW'(r1_dp[3]);
            r2_xs.p.z    <= PW'(r1_dp[4]) - PW'(r1_dp[5]);
            r2_xs.q.x    <= QW'(r1_tp[0]) - QW'(r1_tp[1]);
            r2_xs.q.y    <= QW'(r1_tp[2]) - QW'(r1_tp[3]);
            r2_xs.q.z    <= QW'(r1_tp[4]) - QW'(r1_tp[5]);
        end
    end

endmodule

// ----- src/rti_dot.sv -----
// ----------------------------------------------------------------------------
// rti_dot
// det = e1.P, nu = T.P, nv = D.Q. Wide multiplicands are cut in two
// partial products, recombined, then the three terms are summed.
// ----------------------------------------------------------------------------
module rti_dot (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rti_pkg::t_v32  i_dir,
    input  logic           i_valid,
    output logic           o_ready,
    input  rti_pkg::t_xs   i_xs,
    output logic           o_valid,
    input  logic           i_ready,
    output rti_pkg::t_dots o_dots
);
    import rti_pkg::*;

    localparam int NS  = 3;
    localparam int PHW = PW - SPLIT + EW;       // P high slice product
    localparam int PLW = SPLIT + 1 + EW;        // P low slice product
    localparam int QHW = QW - SPLIT + CW;
    localparam int QLW = SPLIT + 1 + CW;

    logic [NS:0]   en;
    logic [NS-1:0] r_vld;

    logic signed [PW-1:0] p_c  [3];
    logic signed [QW-1:0] q_c  [3];
    logic signed [EW-1:0] e1_c [3];
    logic signed [EW-1:0] t_c  [3];
    logic signed [CW-1:0] d_c  [3];

    logic signed [PHW-1:0] r0_dh [3];
    logic signed [PLW-1:0] r0_dl [3];
    logic signed [PHW-1:0] r0_uh [3];
    logic signed [PLW-1:0] r0_ul [3];
    logic signed [QHW-1:0] r0_vh [3];
    logic signed [QLW-1:0] r0_vl [3];
    t_tri                  r0_tri;

    logic signed [MW-1:0] r1_d [3];
    logic signed [MW-1:0] r1_u [3];
    logic signed [MW-1:0] r1_v [3];
    t_tri                 r1_tri;

    t_dots r2_dots;

    assign p_c[0]  = i_xs.p.x;
    assign p_c[1]  = i_xs.p.y;
    assign p_c[2]  = i_xs.p.z;
    assign q_c[0]  = i_xs.q.x;
    assign q_c[1]  = i_xs.q.y;
    assign q_c[2]  = i_xs.q.z;
    assign e1_c[0] = i_xs.trg.e1.x;
    assign e1_c[1] = i_xs.trg.e1.y;
    assign e1_c[2] = i_xs.trg.e1.z;
    assign t_c[0]  = i_xs.t.x;
    assign t_c[1]  = i_xs.t.y;
    assign t_c[2]  = i_xs.t.z;
    assign d_c[0]  = i_dir.x;
    assign d_c[1]  = i_dir.y;
    assign d_c[2]  = i_dir.z;

    always_comb begin
        en[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_vld[NS-1];
    assign o_dots  = r2_dots;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) r_vld[0] <= i_valid;
            for (int k = 1; k < NS; k++) begin
                if (en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            for (int k = 0; k < 3; k++) begin
                r0_dh[k] <= $signed(p_c[k][PW-1:SPLIT]) * e1_c[k];
                r0_dl[k] <= $signed({1'b0, p_c[k][SPLIT-1:0]}) * e1_c[k];
                r0_uh[k] <= $signed(p_c[k][PW-1:SPLIT]) * t_c[k];
                r0_ul[k] <= $signed({1'b0, p_c[k][SPLIT-1:0]}) * t_c[k];
                r0_vh[k] <= $signed(q_c[k][QW-1:SPLIT]) * d_c[k];
                r0_vl[k] <= $signed({1'b0, q_c[k][SPLIT-1:0]}) * d_c[k];
            end
            r0_tri <= i_xs.trg;
        end
        if (en[1]) begin
            for (int k = 0; k < 3; k++) begin
                r1_d[k] <= (MW'(r0_dh[k]) <<< SPLIT) + MW'(r0_dl[k]);
                r1_u[k] <= (MW'(r0_uh[k]) <<< SPLIT) + MW'(r0_ul[k]);
                r1_v[k] <= (MW'(r0_vh[k]) <<< SPLIT) + MW'(r0_vl[k]);
            end
            r1_tri <= r0_tri;
        end
        if (en[2]) begin
            r2_dots.det <= DW'(r1_d[0]) + DW'(r1_d[1]) + DW'(r1_d[2]);
            r2_dots.nu  <= DW'(r1_u[0]) + DW'(r1_u[1]) + DW'(r1_u[2]);
            r2_dots.nv  <= DW'(r1_v[0]) + DW'(r1_v[1]) + DW'(r1_v[2]);
            r2_dots.trg <= r1_tri;
        end
    end

endmodule

// ----- src/rti_div.sv -----
// ----------------------------------------------------------------------------
// rti_div
// Pipelined restoring divider, two lanes sharing det: u = nu/det, v = nv/det
// as signed fixed point, one quotient bit per stage. Also flags the
// parallel case. Quotients that overflow the lane saturate; only their
// side of the range tests matters downstream.
// ----------------------------------------------------------------------------
module rti_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  rti_pkg::t_dots           i_dots,
    output logic                     o_valid,
    input  logic                     i_ready,
    output rti_pkg::t_tri            o_tri,
    output logic                     o_par,
    output logic signed [FRAC_BITS+3:0] o_u,
    output logic signed [FRAC_BITS+3:0] o_v
);
    import rti_pkg::*;

    localparam int QB  = FRAC_BITS + 3;         // quotient bits
    localparam int UW  = QB + 1;
    localparam int NW  = DW + FRAC_BITS;        // shifted numerator
    localparam int RW  = DW + 1;
    localparam int NS  = QB + 3;
    localparam int EPS = ((1 << FRAC_BITS) + 9999) / 10000;
    localparam logic [DW-1:0] THR = DW'(EPS) << (2 * FRAC_BITS);

    logic [NS:0]   en;
    logic [NS-1:0] r_vld;

    // prep stage
    logic [DW-1:0] r0_nu, r0_nv, r0_d;
    logic          r0_su, r0_sv;
    t_tri          r0_tri;

    // step registers, index 0 is the setup stage
    logic [DW-1:0] r_rem_u [QB+1];
    logic [DW-1:0] r_rem_v [QB+1];
    logic [QB-1:0] r_low_u [QB+1];
    logic [QB-1:0] r_low_v [QB+1];
    logic [QB-1:0] r_q_u   [QB+1];
    logic [QB-1:0] r_q_v   [QB+1];
    logic [DW-1:0] r_d     [QB+1];
    logic          r_par   [QB+1];
    logic          r_ovu   [QB+1];
    logic          r_ovv   [QB+1];
    logic          r_su    [QB+1];
    logic          r_sv    [QB+1];
    t_tri          r_tri   [QB+1];

    logic [DW-1:0] n_rem_u [QB+1];
    logic [DW-1:0] n_rem_v [QB+1];
    logic [QB-1:0] n_q_u   [QB+1];
    logic [QB-1:0] n_q_v   [QB+1];

    logic [NW-1:0] nnu, nnv;

    logic signed [UW-1:0] r_uq, r_vq, n_u, n_v;
    logic                 r_par_o;
    t_tri                 r_tri_o;

    always_comb begin
        en[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_vld[NS-1];
    assign o_tri   = r_tri_o;
    assign o_par   = r_par_o;
    assign o_u     = r_uq;
    assign o_v     = r_vq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) r_vld[0] <= i_valid;
            for (int k = 1; k < NS; k++) begin
                if (en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    assign nnu = {r0_nu, {FRAC_BITS{1'b0}}};
    assign nnv = {r0_nv, {FRAC_BITS{1'b0}}};

    always_comb begin
        logic [RW-1:0] tu, tv;
        logic          gu, gv;
        tu = '0;
        tv = '0;
        gu = 1'b0;
        gv = 1'b0;
        n_rem_u[0] = '0;
        n_rem_v[0] = '0;
        n_q_u[0]   = '0;
        n_q_v[0]   = '0;
        for (int j = 1; j <= QB; j++) begin
            tu = {r_rem_u[j-1], r_low_u[j-1][QB-1]};
            tv = {r_rem_v[j-1], r_low_v[j-1][QB-1]};
            gu = tu >= {1'b0, r_d[j-1]};
            gv = tv >= {1'b0, r_d[j-1]};
            n_rem_u[j] = gu ? DW'(tu - {1'b0, r_d[j-1]}) : DW'(tu);
            n_rem_v[j] = gv ? DW'(tv - {1'b0, r_d[j-1]}) : DW'(tv);
            n_q_u[j]   = {r_q_u[j-1][QB-2:0], gu};
            n_q_v[j]   = {r_q_v[j-1][QB-2:0], gv};
        end
    end

    always_comb begin
        n_u = UW'(r_ovu[QB] ? {QB{1'b1}} : r_q_u[QB]);
        n_v = UW'(r_ovv[QB] ? {QB{1'b1}} : r_q_v[QB]);
        if (r_su[QB]) n_u = -n_u;
        if (r_sv[QB]) n_v = -n_v;
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r0_nu  <= i_dots.nu[DW-1]  ? DW'(-i_dots.nu)  : DW'(i_dots.nu);
            r0_nv  <= i_dots.nv[DW-1]  ? DW'(-i_dots.nv)  : DW'(i_dots.nv);
            r0_d   <= i_dots.det[DW-1] ? DW'(-i_dots.det) : DW'(i_dots.det);
            r0_su  <= i_dots.nu[DW-1] ^ i_dots.det[DW-1];
            r0_sv  <= i_dots.nv[DW-1] ^ i_dots.det[DW-1];
            r0_tri <= i_dots.trg;
        end
        // setup: quotient overflows when the top part already reaches det
        if (en[1]) begin
            r_rem_u[0] <= DW'(nnu[NW-1:QB]);
            r_rem_v[0] <= DW'(nnv[NW-1:QB]);
            r_low_u[0] <= nnu[QB-1:0];
            r_low_v[0] <= nnv[QB-1:0];
            r_q_u[0]   <= '0;
            r_q_v[0]   <= '0;
            r_ovu[0]   <= DW'(nnu[NW-1:QB]) >= r0_d;
            r_ovv[0]   <= DW'(nnv[NW-1:QB]) >= r0_d;
            r_par[0]   <= r0_d < THR;
            r_d[0]     <= r0_d;
            r_su[0]    <= r0_su;
            r_sv[0]    <= r0_sv;
            r_tri[0]   <= r0_tri;
        end
        for (int j = 1; j <= QB; j++) begin
            if (en[j+1]) begin
                r_rem_u[j] <= n_rem_u[j];
                r_rem_v[j] <= n_rem_v[j];
                r_low_u[j] <= {r_low_u[j-1][QB-2:0], 1'b0};
                r_low_v[j] <= {r_low_v[j-1][QB-2:0], 1'b0};
                r_q_u[j]   <= n_q_u[j];
                r_q_v[j]   <= n_q_v[j];
                r_ovu[j]   <= r_ovu[j-1];
                r_ovv[j]   <= r_ovv[j-1];
                r_par[j]   <= r_par[j-1];
                r_d[j]     <= r_d[j-1];
                r_su[j]    <= r_su[j-1];
                r_sv[j]    <= r_sv[j-1];
                r_tri[j]   <= r_tri[j-1];
            end
        end
        if (en[NS-1]) begin
            r_uq    <= n_u;
            r_vq    <= n_v;
            r_par_o <= r_par[QB];
            r_tri_o <= r_tri[QB];
        end
    end

endmodule

// ----- src/rti_point.sv -----
// ----------------------------------------------------------------------------
// rti_point
// Range tests on u and v, outcome code, and the hit point
// a + floor((e1*u + e2*v) / 2^F) saturated to 32 bits. Output register
// is the last stage.
// ----------------------------------------------------------------------------
module rti_point #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  rti_pkg::t_tri               i_tri,
    input  logic                        i_par,
    input  logic signed [FRAC_BITS+3:0] i_u,
    input  logic signed [FRAC_BITS+3:0] i_v,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [1:0]                  o_outcome,
    output rti_pkg::t_v32               o_hit
);
    import rti_pkg::*;

    localparam int NS  = 3;
    localparam int UW  = FRAC_BITS + 4;
    localparam int UMW = FRAC_BITS + 2;         // u, v on a hit fit here
    localparam int MP  = EW + UMW;
    localparam int SW  = MP + 1;
    localparam int FW  = SW - FRAC_BITS;
    localparam int GW  = FW + 1;
    localparam int EPS = ((1 << FRAC_BITS) + 9999) / 10000;
    localparam logic signed [UW-1:0] LO = UW'(-EPS);
    localparam logic signed [UW-1:0] HI = UW'((1 << FRAC_BITS) + EPS);

    logic [NS:0]   en;
    logic [NS-1:0] r_vld;

    logic signed [EW-1:0] e1_c [3];
    logic signed [EW-1:0] e2_c [3];
    logic signed [CW-1:0] a0_c [3];

    logic signed [UW:0] uv;
    logic [1:0]         n_oc;

    logic signed [MP-1:0] r0_pu [3];
    logic signed [MP-1:0] r0_pv [3];
    logic [1:0]           r0_oc;
    t_v32                 r0_a;

    logic signed [SW-1:0] r1_s [3];
    logic [1:0]           r1_oc;
    logic signed [CW-1:0] r1_a [3];

    logic signed [GW-1:0] p_c  [3];
    logic signed [CW-1:0] n_hp [3];

    logic [1:0] r_oc;
    t_v32       r_hit;

    assign e1_c[0] = i_tri.e1.x;
    assign e1_c[1] = i_tri.e1.y;
    assign e1_c[2] = i_tri.e1.z;
    assign e2_c[0] = i_tri.e2.x;
    assign e2_c[1] = i_tri.e2.y;
    assign e2_c[2] = i_tri.e2.z;
    assign a0_c[0] = r0_a.x;
    assign a0_c[1] = r0_a.y;
    assign a0_c[2] = r0_a.z;

    always_comb begin
        en[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_ready   = en[0];
    assign o_valid   = r_vld[NS-1];
    assign o_outcome = r_oc;
    assign o_hit     = r_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) r_vld[0] <= i_valid;
            for (int k = 1; k < NS; k++) begin
                if (en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_comb begin
        uv = (UW+1)'(i_u) + (UW+1)'(i_v);
        if (i_par) begin
            n_oc = OUT_PAR;
        end else if (i_u < LO || i_u > HI) begin
            n_oc = OUT_UOUT;
        end else if (i_v < LO || uv > (UW+1)'(HI)) begin
            n_oc = OUT_VOUT;
        end else begin
            n_oc = OUT_HIT;
        end
    end

    // floor division is the arithmetic shift; then saturate to 32 bits
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            p_c[k] = GW'(r1_a[k]) + GW'($signed(r1_s[k][SW-1:FRAC_BITS]));
            if (!p_c[k][GW-1] && (|p_c[k][GW-2:CW-1])) begin
                n_hp[k] = {1'b0, {(CW-1){1'b1}}};
            end else if (p_c[k][GW-1] && !(&p_c[k][GW-2:CW-1])) begin
                n_hp[k] = {1'b1, {(CW-1){1'b0}}};
            end else begin
                n_hp[k] = p_c[k][CW-1:0];
            end
            if (r1_oc != OUT_HIT) n_hp[k] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            for (int k = 0; k < 3; k++) begin
                r0_pu[k] <= e1_c[k] * $signed(i_u[UMW-1:0]);
                r0_pv[k] <= e2_c[k] * $signed(i_v[UMW-1:0]);
            end
            r0_oc <= n_oc;
            r0_a  <= i_tri.a;
        end
        if (en[1]) begin
            for (int k = 0; k < 3; k++) begin
                r1_s[k] <= SW'(r0_pu[k]) + SW'(r0_pv[k]);
                r1_a[k] <= a0_c[k];
            end
            r1_oc <= r0_oc;
        end
        if (en[2]) begin
            r_oc    <= r1_oc;
            r_hit.x <= n_hp[0];
            r_hit.y <= n_hp[1];
            r_hit.z <= n_hp[2];
        end
    end

endmodule
